// File: rtl/core/xufd_pkg.sv
// Package for the x86 undefined-flags decoder.
// Holds the stream item types, opcode and flag constants, parse phases and mask helpers.
// No dependencies.
`default_nettype none

package xufd_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int MASK_W = 12;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    // EFLAGS bit positions inside the mask
    localparam logic [MASK_W-1:0] FL_C = MASK_W'(1 << 0);
    localparam logic [MASK_W-1:0] FL_P = MASK_W'(1 << 2);
    localparam logic [MASK_W-1:0] FL_A = MASK_W'(1 << 4);
    localparam logic [MASK_W-1:0] FL_Z = MASK_W'(1 << 6);
    localparam logic [MASK_W-1:0] FL_S = MASK_W'(1 << 7);
    localparam logic [MASK_W-1:0] FL_O = MASK_W'(1 << 11);

    localparam logic [MASK_W-1:0] MUL_FLAGS = FL_S | FL_Z | FL_A | FL_P;
    localparam logic [MASK_W-1:0] DIV_FLAGS = FL_C | FL_O | FL_S | FL_Z | FL_A | FL_P;
    localparam logic [MASK_W-1:0] BSX_FLAGS = FL_O | FL_S | FL_A | FL_P | FL_C;
    localparam logic [MASK_W-1:0] SHD_FLAGS = FL_O | FL_A;
    localparam logic [MASK_W-1:0] ALL_FLAGS = FL_C | FL_P | FL_A | FL_Z | FL_S | FL_O;

    // One-byte opcodes
    localparam logic [BYTE_W-1:0] OP_OPSIZE  = 8'h66;
    localparam logic [BYTE_W-1:0] OP_ESCAPE  = 8'h0f;
    localparam logic [BYTE_W-1:0] OP_IMUL_IZ = 8'h69;
    localparam logic [BYTE_W-1:0] OP_IMUL_IB = 8'h6b;
    localparam logic [BYTE_W-1:0] OP_G2_IB0  = 8'hc0;
    localparam logic [BYTE_W-1:0] OP_G2_IB1  = 8'hc1;
    localparam logic [BYTE_W-1:0] OP_G2_ONE0 = 8'hd0;
    localparam logic [BYTE_W-1:0] OP_G2_ONE1 = 8'hd1;
    localparam logic [BYTE_W-1:0] OP_G2_CL0  = 8'hd2;
    localparam logic [BYTE_W-1:0] OP_G2_CL1  = 8'hd3;
    localparam logic [BYTE_W-1:0] OP_G3_0    = 8'hf6;
    localparam logic [BYTE_W-1:0] OP_G3_1    = 8'hf7;

    // Opcodes after the 0F escape
    localparam logic [BYTE_W-1:0] OP_SHLD_IB = 8'ha4;
    localparam logic [BYTE_W-1:0] OP_SHLD_CL = 8'ha5;
    localparam logic [BYTE_W-1:0] OP_SHRD_IB = 8'hac;
    localparam logic [BYTE_W-1:0] OP_SHRD_CL = 8'had;
    localparam logic [BYTE_W-1:0] OP_IMUL_RM = 8'haf;
    localparam logic [BYTE_W-1:0] OP_BSF     = 8'hbc;
    localparam logic [BYTE_W-1:0] OP_BSR     = 8'hbd;

    // Shift counts are masked to five bits
    localparam logic [BYTE_W-1:0] COUNT_MASK = 8'h1f;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_ESC       = 3'd1,
        PH_SHD_MODRM = 3'd2,
        PH_SHD_IMM   = 3'd3,
        PH_G2I_MODRM = 3'd4,
        PH_G2I_IMM   = 3'd5,
        PH_G2R_MODRM = 3'd6,
        PH_G3_MODRM  = 3'd7
    } phase_t;

    // One instruction byte with its side information
    typedef struct packed {
        logic              first_byte;
        logic [BYTE_W-1:0] code_byte;
        logic [BYTE_W-1:0] count_reg;
    } item_t;

    // Parser result toward the output register
    typedef struct packed {
        logic              valid;
        logic [MASK_W-1:0] undefined_mask;
    } result_t;

    // ModRM reg field 4..7 selects the shift forms and MUL/IMUL/DIV/IDIV halves
    function automatic logic reg_high(input logic [BYTE_W-1:0] modrm);
        return modrm[5];
    endfunction

    // Group 2 undefined flags for a given raw count
    function automatic logic [MASK_W-1:0] group2_mask(input logic [BYTE_W-1:0] count,
                                                      input logic shift_kind);
        logic [BYTE_W-1:0] c;
        logic [MASK_W-1:0] m;
        c = count & COUNT_MASK;
        m = '0;
        if (c != '0) begin
            if (shift_kind) m = m | FL_A;
            if (c > BYTE_W'(1)) m = m | FL_O;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/x86_undefined_flags_decoder.sv
// x86 undefined-flags decoder, top level.
//
// Input stream (s_*): one instruction byte per transfer. s_tdata[7:0] is the
// byte, s_tdata[15:8] the current CL value; s_tuser[0] marks the first byte of
// a new instruction and restarts the parse. 0x66 prefixes are skipped.
// Result stream (m_*): m_tdata[11:0] is the mask of EFLAGS bits the
// instruction leaves undefined (C, P, A, Z, S, O at their EFLAGS positions),
// upper bits zero. At most one result per instruction, sent with the byte
// that settles it; bytes after that give nothing until the next first byte.
// The byte that settles the result first enters the input register; its mask is
// then loaded into the result register, which drives m_tvalid.
// Throughput: one byte per cycle while the result side does not stall; the parse
// state update is a single combinational step between the two registers.
// Reset (aresetn low, synchronous): both registers empty, parser idle and
// expecting an opcode.
// Stall: while m_tvalid is high and m_tready low, the result holds and
// s_tready drops once the input register is also full.
`default_nettype none

module x86_undefined_flags_decoder
    import xufd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [7:0] code_byte, [15:8] count_reg
    input  wire logic [0:0]           s_tuser,  // [0] first_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata   // [11:0] undefined_mask, [15:12] zero
);

    item_t             in_item;
    item_t             item;
    logic              item_valid;
    logic              advance;
    result_t           result;
    logic [MASK_W-1:0] out_mask;

    // Unpack the input transfer
    assign in_item.first_byte = s_tuser[0];
    assign in_item.code_byte  = s_tdata[BYTE_W-1:0];
    assign in_item.count_reg  = s_tdata[2*BYTE_W-1:BYTE_W];

    xufd_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    xufd_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .result     (result)
    );

    xufd_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .result    (result),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_mask  (out_mask),
        .advance   (advance)
    );

    // Pack the result transfer
    assign m_tdata = {{(M_TDATA_W-MASK_W){1'b0}}, out_mask};

    // Both stages come out of reset empty
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Only the six defined flag positions may be reported
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[MASK_W-1:0] & ~ALL_FLAGS) == '0))
        else $error("mask holds a bit outside the flag set");

    // A ready receiver never stalls the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while result side is ready");

endmodule

`default_nettype wire

// File: rtl/core/xufd_in_stage.sv
// Input register of the undefined-flags decoder.
// Holds one accepted byte until the parse stage takes it; uses xufd_pkg.
`default_nettype none

module xufd_in_stage
    import xufd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    input  wire logic  advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // Accept when empty or when the held byte moves on this cycle
    assign in_ready = !valid_reg || advance;
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on each transfer
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// File: rtl/core/xufd_parser.sv
// Parse state and mask decode of the undefined-flags decoder.
// Tracks the instruction phase byte by byte and forms the flag mask; uses xufd_pkg.
`default_nettype none

module xufd_parser
    import xufd_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  item_valid,
    input  wire item_t item,
    input  wire logic  advance,
    output result_t    result
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   arith_reg;
    logic   arith_next;
    logic   take;
    logic [BYTE_W-1:0] b;
    logic [BYTE_W-1:0] cl;

    assign take = item_valid && advance;
    assign b    = item.code_byte;
    assign cl   = item.count_reg;

    // Next phase, flag and result for the byte in the input register
    always_comb begin
        phase_next            = phase_reg;
        arith_next            = arith_reg;
        result.valid          = 1'b0;
        result.undefined_mask = '0;

        if (item.first_byte || (phase_reg == PH_IDLE && !arith_reg)) begin
            // Opcode byte: parse restarts with the flag clear
            phase_next = PH_IDLE;
            arith_next = 1'b0;
            case (b)
                OP_OPSIZE: begin
                    phase_next = PH_IDLE;
                end
                OP_ESCAPE: begin
                    phase_next = PH_ESC;
                end
                OP_IMUL_IZ, OP_IMUL_IB: begin
                    arith_next            = 1'b1;
                    result.valid          = 1'b1;
                    result.undefined_mask = MUL_FLAGS;
                end
                OP_G2_IB0, OP_G2_IB1: begin
                    phase_next = PH_G2I_MODRM;
                end
                OP_G2_ONE0, OP_G2_ONE1: begin
                    phase_next = PH_G2R_MODRM;
                end
                OP_G2_CL0, OP_G2_CL1: begin
                    phase_next = PH_G2R_MODRM;
                    arith_next = 1'b1;
                end
                OP_G3_0, OP_G3_1: begin
                    phase_next = PH_G3_MODRM;
                end
                default: begin
                    arith_next   = 1'b1;
                    result.valid = 1'b1;
                end
            endcase
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    // Instruction already answered: drop trailing bytes
                end
                PH_ESC: begin
                    if (b == OP_SHLD_IB || b == OP_SHRD_IB) begin
                        phase_next = PH_SHD_MODRM;
                    end else begin
                        phase_next   = PH_IDLE;
                        arith_next   = 1'b1;
                        result.valid = 1'b1;
                        case (b)
                            OP_SHLD_CL, OP_SHRD_CL:
                                result.undefined_mask = (cl != '0) ? SHD_FLAGS : '0;
                            OP_IMUL_RM:
                                result.undefined_mask = MUL_FLAGS;
                            OP_BSF, OP_BSR:
                                result.undefined_mask = BSX_FLAGS;
                            default:
                                result.undefined_mask = '0;
                        endcase
                    end
                end
                PH_SHD_MODRM: begin
                    phase_next = PH_SHD_IMM;
                end
                PH_SHD_IMM: begin
                    phase_next            = PH_IDLE;
                    arith_next            = 1'b1;
                    result.valid          = 1'b1;
                    result.undefined_mask = (b != '0) ? SHD_FLAGS : '0;
                end
                PH_G2I_MODRM: begin
                    phase_next = PH_G2I_IMM;
                    arith_next = reg_high(b);
                end
                PH_G2I_IMM: begin
                    phase_next            = PH_IDLE;
                    arith_next            = 1'b1;
                    result.valid          = 1'b1;
                    result.undefined_mask = group2_mask(b, arith_reg);
                end
                PH_G2R_MODRM: begin
                    phase_next            = PH_IDLE;
                    arith_next            = 1'b1;
                    result.valid          = 1'b1;
                    result.undefined_mask = group2_mask(arith_reg ? cl : BYTE_W'(1),
                                                        reg_high(b));
                end
                PH_G3_MODRM: begin
                    phase_next   = PH_IDLE;
                    arith_next   = 1'b1;
                    result.valid = 1'b1;
                    if (b[5]) begin
                        result.undefined_mask = b[4] ? DIV_FLAGS : MUL_FLAGS;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Only a byte held in the input register produces a result
        result.valid = result.valid && item_valid;
    end

    // Advance the parse state once per byte taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            arith_reg <= 1'b0;
        end else if (take) begin
            phase_reg <= phase_next;
            arith_reg <= arith_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/xufd_out_stage.sv
// Result register of the undefined-flags decoder.
// Holds one mask until the receiver takes it; uses xufd_pkg.
`default_nettype none

module xufd_out_stage
    import xufd_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire result_t result,
    input  wire logic    out_ready,
    output logic         out_valid,
    output logic [MASK_W-1:0] out_mask,
    output logic         advance
);

    logic              valid_reg;
    logic              valid_next;
    logic [MASK_W-1:0] mask_reg;

    // Stage moves when empty or when the held mask is taken
    assign advance = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load the mask with each new result
    always_ff @(posedge aclk) begin
        if (advance && result.valid) begin
            mask_reg <= result.undefined_mask;
        end
    end

    assign out_valid = valid_reg;
    assign out_mask  = mask_reg;

endmodule

`default_nettype wire
